### sv/nufd_pkg.sv
package nufd_pkg;

    // field widths
    localparam int BYTE_W      = 8;
    localparam int EVENT_W     = 2;
    localparam int LENGTH_W    = 17;
    localparam int REASON_W    = 3;
    localparam int NMEA_MAX_W  = 11;
    localparam int UBX_MAX_W   = 16;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NMEA_MAX_CHARS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UBX_MAX_PAYLOAD = 1'd1;

    localparam logic [NMEA_MAX_W-1:0] NMEA_MAX_RESET = 11'd256;
    localparam logic [UBX_MAX_W-1:0]  UBX_MAX_RESET  = 16'd252;

    // framing characters
    localparam logic [BYTE_W-1:0] CH_DOLLAR     = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR       = 8'h2A;
    localparam logic [BYTE_W-1:0] UBX_SYNC1     = 8'hB5;
    localparam logic [BYTE_W-1:0] UBX_SYNC2     = 8'h62;
    localparam logic [BYTE_W-1:0] NMEA_MAX_CODE = 8'd127;
    localparam logic [BYTE_W-1:0] HIGH_NIBBLE   = 8'hF0;
    localparam logic [BYTE_W-1:0] CH_CR         = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF         = 8'd10;

    // event codes
    localparam logic [EVENT_W-1:0] EV_BODY    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_ACCEPT  = 2'd1;
    localparam logic [EVENT_W-1:0] EV_DISCARD = 2'd2;

    // discard reasons
    localparam logic [REASON_W-1:0] RS_NONE      = 3'd0;
    localparam logic [REASON_W-1:0] RS_BAD_CHAR  = 3'd1;
    localparam logic [REASON_W-1:0] RS_TOO_LONG  = 3'd2;
    localparam logic [REASON_W-1:0] RS_BAD_TERM  = 3'd3;
    localparam logic [REASON_W-1:0] RS_CHECKSUM  = 3'd4;
    localparam logic [REASON_W-1:0] RS_RESTARTED = 3'd5;

    localparam logic                PROTO_NMEA = 1'b0;

    typedef enum logic [10:0] {
        PH_WAIT   = 11'b000_0000_0001,
        PH_NBODY  = 11'b000_0000_0010,
        PH_NCS1   = 11'b000_0000_0100,
        PH_NCS2   = 11'b000_0000_1000,
        PH_NCR    = 11'b000_0001_0000,
        PH_NLF    = 11'b000_0010_0000,
        PH_USYNC2 = 11'b000_0100_0000,
        PH_UHDR   = 11'b000_1000_0000,
        PH_UPAY   = 11'b001_0000_0000,
        PH_UCK1   = 11'b010_0000_0000,
        PH_UCK2   = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        t_phase                phase;
        logic                  in_nmea;
        logic [BYTE_W-1:0]     xor_sum;
        logic [BYTE_W-1:0]     fletcher_a;
        logic [BYTE_W-1:0]     fletcher_b;
        logic [BYTE_W-1:0]     length_low;
        logic [UBX_MAX_W-1:0]  payload_length;
        logic [LENGTH_W-1:0]   body_count;
    } t_state;

    typedef struct packed {
        logic [EVENT_W-1:0]  event_res;
        logic                protocol;
        logic [BYTE_W-1:0]   body_byte;
        logic [LENGTH_W-1:0] frame_length;
        logic [REASON_W-1:0] discard_reason;
    } t_result;

    localparam t_state STATE_RESET = '{
        phase:          PH_WAIT,
        in_nmea:        1'b1,
        xor_sum:        '0,
        fletcher_a:     '0,
        fletcher_b:     '0,
        length_low:     '0,
        payload_length: '0,
        body_count:     '0
    };

endpackage

### sv/nufd_rx_if.sv
interface nufd_rx_if;
    import nufd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

### sv/nufd_res_if.sv
interface nufd_res_if;
    import nufd_pkg::*;

    logic                valid;
    logic                ready;
    logic [EVENT_W-1:0]  event_res;
    logic                protocol;
    logic [BYTE_W-1:0]   body_byte;
    logic [LENGTH_W-1:0] frame_length;
    logic [REASON_W-1:0] discard_reason;

    modport source (output valid, output event_res, output protocol, output body_byte,
                    output frame_length, output discard_reason, input ready);
    modport sink   (input valid, input event_res, input protocol, input body_byte,
                    input frame_length, input discard_reason, output ready);
endinterface

### sv/nufd_step.sv
module nufd_step (
    input  nufd_pkg::t_state                          i_state,
    input  logic [nufd_pkg::BYTE_W-1:0]               i_byte,
    input  logic [nufd_pkg::NMEA_MAX_W-1:0]           i_nmea_max,
    input  logic [nufd_pkg::UBX_MAX_W-1:0]            i_ubx_max,
    output nufd_pkg::t_state                          o_state,
    output logic                                      o_has_res,
    output nufd_pkg::t_result                         o_res
);
    import nufd_pkg::*;

    t_state              n_st;
    t_state              start_st;
    logic                is_start;
    logic                hex_ok;
    logic [3:0]          hex_val;
    logic [BYTE_W-1:0]   fa_new;
    logic [BYTE_W-1:0]   fb_new;
    logic [UBX_MAX_W-1:0] hdr_len;
    logic [EVENT_W-1:0]  ev;
    logic [REASON_W-1:0] rs;
    logic [BYTE_W-1:0]   bb;
    logic                has;

    assign is_start = (i_byte == CH_DOLLAR) || (i_byte == UBX_SYNC1);
    assign fa_new   = i_state.fletcher_a + i_byte;
    assign fb_new   = i_state.fletcher_b + fa_new;
    assign hdr_len  = {i_byte, i_state.length_low};

    // hex digit 0-9 / A-F
    always_comb begin
        hex_ok  = 1'b0;
        hex_val = 4'd0;
        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
            hex_ok  = 1'b1;
            hex_val = 4'(i_byte - 8'h30);
        end else if (i_byte >= 8'h41 && i_byte <= 8'h46) begin
            hex_ok  = 1'b1;
            hex_val = 4'(i_byte - 8'h37);
        end
    end

    // state after a start byte opens a new frame
    always_comb begin
        start_st            = i_state;
        start_st.body_count = '0;
        if (i_byte == CH_DOLLAR) begin
            start_st.in_nmea = 1'b1;
            start_st.xor_sum = '0;
            start_st.phase   = PH_NBODY;
        end else begin
            start_st.in_nmea    = 1'b0;
            start_st.fletcher_a = '0;
            start_st.fletcher_b = '0;
            start_st.phase      = PH_USYNC2;
        end
    end

    always_comb begin
        n_st = i_state;
        has  = 1'b0;
        ev   = EV_BODY;
        rs   = RS_NONE;
        bb   = '0;
        if (is_start && (i_state.phase == PH_WAIT || i_state.in_nmea)) begin
            if (i_state.phase != PH_WAIT) begin
                has = 1'b1;
                ev  = EV_DISCARD;
                rs  = RS_RESTARTED;
            end
            n_st = start_st;
        end else begin
            unique case (i_state.phase)
                PH_WAIT: begin
                end
                PH_NBODY: begin
                    if (i_byte > NMEA_MAX_CODE) begin
                        n_st.phase = PH_WAIT;
                        has = 1'b1; ev = EV_DISCARD; rs = RS_BAD_CHAR;
                    end else if (i_byte == CH_STAR) begin
                        n_st.phase = PH_NCS1;
                    end else if (i_state.body_count >= LENGTH_W'(i_nmea_max)) begin
                        n_st.phase = PH_WAIT;
                        has = 1'b1; ev = EV_DISCARD; rs = RS_TOO_LONG;
                    end else begin
                        n_st.xor_sum    = i_state.xor_sum ^ i_byte;
                        n_st.body_count = i_state.body_count + 1'b1;
                        has = 1'b1; bb = i_byte;
                    end
                end
                PH_NCS1, PH_NCS2: begin
                    if (!hex_ok) begin
                        n_st.phase = PH_WAIT;
                        has = 1'b1; ev = EV_DISCARD; rs = RS_BAD_CHAR;
                    end else if (i_state.phase == PH_NCS1) begin
                        n_st.xor_sum = i_state.xor_sum ^ ({hex_val, 4'h0} & HIGH_NIBBLE);
                        n_st.phase   = PH_NCS2;
                    end else begin
                        n_st.xor_sum = i_state.xor_sum ^ {4'h0, hex_val};
                        n_st.phase   = PH_NCR;
                    end
                end
                PH_NCR: begin
                    if (i_byte != CH_CR) begin
                        n_st.phase = PH_WAIT;
                        has = 1'b1; ev = EV_DISCARD; rs = RS_BAD_TERM;
                    end else begin
                        n_st.phase = PH_NLF;
                    end
                end
                PH_NLF: begin
                    n_st.phase = PH_WAIT;
                    has = 1'b1;
                    if (i_byte != CH_LF) begin
                        ev = EV_DISCARD; rs = RS_BAD_TERM;
                    end else if (i_state.xor_sum != '0) begin
                        ev = EV_DISCARD; rs = RS_CHECKSUM;
                    end else begin
                        ev = EV_ACCEPT;
                    end
                end
                PH_USYNC2: begin
                    if (i_byte == UBX_SYNC2) begin
                        n_st.phase = PH_UHDR;
                    end else begin
                        has = 1'b1; ev = EV_DISCARD; rs = RS_RESTARTED;
                        if (is_start) begin
                            n_st = start_st;
                        end else begin
                            n_st.phase = PH_WAIT;
                        end
                    end
                end
                PH_UHDR: begin
                    if (i_state.body_count == LENGTH_W'(3)) begin
                        if (hdr_len > i_ubx_max) begin
                            n_st.phase = PH_WAIT;
                            has = 1'b1; ev = EV_DISCARD; rs = RS_TOO_LONG;
                        end else begin
                            n_st.payload_length = hdr_len;
                            n_st.fletcher_a     = fa_new;
                            n_st.fletcher_b     = fb_new;
                            n_st.body_count     = i_state.body_count + 1'b1;
                            n_st.phase          = (hdr_len == '0) ? PH_UCK1 : PH_UPAY;
                            has = 1'b1; bb = i_byte;
                        end
                    end else begin
                        if (i_state.body_count == LENGTH_W'(2)) begin
                            n_st.length_low = i_byte;
                        end
                        n_st.fletcher_a = fa_new;
                        n_st.fletcher_b = fb_new;
                        n_st.body_count = i_state.body_count + 1'b1;
                        has = 1'b1; bb = i_byte;
                    end
                end
                PH_UPAY: begin
                    n_st.fletcher_a = fa_new;
                    n_st.fletcher_b = fb_new;
                    n_st.body_count = i_state.body_count + 1'b1;
                    if (n_st.body_count >= LENGTH_W'(i_state.payload_length) + LENGTH_W'(4)) begin
                        n_st.phase = PH_UCK1;
                    end
                    has = 1'b1; bb = i_byte;
                end
                PH_UCK1: begin
                    if (i_byte != i_state.fletcher_a) begin
                        n_st.phase = PH_WAIT;
                        has = 1'b1; ev = EV_DISCARD; rs = RS_CHECKSUM;
                    end else begin
                        n_st.phase = PH_UCK2;
                    end
                end
                PH_UCK2: begin
                    n_st.phase = PH_WAIT;
                    has = 1'b1;
                    if (i_byte != i_state.fletcher_b) begin
                        ev = EV_DISCARD; rs = RS_CHECKSUM;
                    end else begin
                        ev = EV_ACCEPT;
                    end
                end
                default: begin
                    n_st.phase = PH_WAIT;
                end
            endcase
        end
    end

    assign o_state                  = n_st;
    assign o_has_res                = has;
    assign o_res.event_res          = ev;
    assign o_res.protocol           = ~i_state.in_nmea;
    assign o_res.body_byte          = bb;
    assign o_res.frame_length       = (ev == EV_BODY) ? n_st.body_count : i_state.body_count;
    assign o_res.discard_reason     = rs;

endmodule

### sv/nmea_ubx_frame_deframer_unit.sv
// NMEA / UBX deframer: takes one received byte per word on i_rx and separates
// interleaved NMEA sentences ('$' body '*' hh CR LF, XOR checked) and UBX frames
// (B5 62, class, id, little-endian length, payload, two-byte Fletcher sum).
// Each body byte comes out as a body word (event 0) with the running length;
// a frame ends with one accept word (event 1) or one discard word (event 2)
// carrying the reason. Bytes that frame but carry no body (start, sync,
// checksum and terminator bytes) give no body word. Throughput is one byte per
// clock unless the output stalls: a byte sits in an input register, the whole
// state update is a single combinational step, and the result lands in an output
// register. Configuration (nmea_max_chars at index 0, ubx_max_payload at index
// 1) is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user must write
// it only while the block is idle, which the block itself does not enforce.
module nmea_ubx_frame_deframer_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    nufd_rx_if.sink                             i_rx,
    nufd_res_if.source                          o_res,
    input  logic                                i_cfg_we,
    input  logic [nufd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [nufd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import nufd_pkg::*;

    // configuration registers
    logic [NMEA_MAX_W-1:0] r_nmea_max;
    logic [UBX_MAX_W-1:0]  r_ubx_max;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;

    // deframer state
    t_state            r_state;
    t_state            n_state;

    // output register
    logic              r_out_valid;
    t_result           r_out;

    logic              step_has;
    t_result           step_res;
    logic              can_load;
    logic              advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nmea_max <= NMEA_MAX_RESET;
            r_ubx_max  <= UBX_MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NMEA_MAX_CHARS:  r_nmea_max <= i_cfg_data[NMEA_MAX_W-1:0];
                CFG_UBX_MAX_PAYLOAD: r_ubx_max  <= i_cfg_data[UBX_MAX_W-1:0];
                default: begin
                end
            endcase
        end
    end

    nufd_step u_step (
        .i_state    (r_state),
        .i_byte     (r_in_byte),
        .i_nmea_max (r_nmea_max),
        .i_ubx_max  (r_ubx_max),
        .o_state    (n_state),
        .o_has_res  (step_has),
        .o_res      (step_res)
    );

    // output register free, or its word leaves this cycle
    assign can_load = !r_out_valid || o_res.ready;
    // a byte with no result never waits on the output side
    assign advance  = r_in_valid && (can_load || !step_has);
    assign i_rx.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_load) begin
            r_out_valid <= advance && step_has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (can_load && advance && step_has) begin
            r_out <= step_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.event_res      = r_out.event_res;
    assign o_res.protocol       = r_out.protocol;
    assign o_res.body_byte      = r_out.body_byte;
    assign o_res.frame_length   = r_out.frame_length;
    assign o_res.discard_reason = r_out.discard_reason;

`ifndef SYNTHESIS
    // a held input byte waits unchanged for the step logic
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input byte lost while stalled");

    // an end-of-frame word other than a restart discard returns the deframer to waiting
    a_end_to_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && step_has && step_res.event_res != EV_BODY
         && step_res.discard_reason != RS_RESTARTED) |=> (r_state.phase == PH_WAIT))
        else $error("frame end did not return to wait");

    // nmea body length never passes the configured limit
    a_nmea_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && step_has && step_res.event_res == EV_BODY
         && step_res.protocol == PROTO_NMEA)
        |=> (r_out.frame_length <= LENGTH_W'(r_nmea_max)))
        else $error("nmea body longer than limit");

    // a stalled output word is not overwritten
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("output word overwritten");
`endif

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import nufd_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 11;
    // margin for the block to drain before touching registers
    localparam int SETTLE_CYCLES   = 6;
    localparam int WATCHDOG_CYCLES = 500_000;

    // byte offsets inside a UBX frame as built here
    localparam int UBX_LEN_LO_POS = 4;
    localparam int UBX_LEN_HI_POS = 5;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    nufd_rx_if  rx_bus ();
    nufd_res_if res_bus ();

    nmea_ubx_frame_deframer_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_rx       (rx_bus),
        .o_res      (res_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // deframer state as this bench tracks it
    t_phase                ph;
    logic                  in_nmea;
    logic [BYTE_W-1:0]     xsum;
    logic [BYTE_W-1:0]     fl_a;
    logic [BYTE_W-1:0]     fl_b;
    logic [BYTE_W-1:0]     len_lo;
    logic [UBX_MAX_W-1:0]  pay_len;
    logic [LENGTH_W-1:0]   body_cnt;
    logic [NMEA_MAX_W-1:0] max_chars;
    logic [UBX_MAX_W-1:0]  max_payload;

    t_result           expected_words[$];
    logic [BYTE_W-1:0] frame_buf[$];
    t_result           got_word;
    t_result           want_word;

    int bytes_sent;
    int words_checked;
    int mismatch_count;
    int frames_accepted;
    int frames_discarded;
    int tx_gap_pct;
    int rx_stall_pct;
    int hold_left;

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ---------------------------------------------------------------
    // expected result words
    // ---------------------------------------------------------------

    task automatic push_word(input logic [EVENT_W-1:0] ev, input logic [BYTE_W-1:0] data,
                             input logic [REASON_W-1:0] reason);
        t_result w;
        w.event_res      = ev;
        w.protocol       = in_nmea ? PROTO_NMEA : ~PROTO_NMEA;
        w.body_byte      = (ev == EV_BODY) ? data : '0;
        w.frame_length   = body_cnt;
        w.discard_reason = reason;
        expected_words.push_back(w);
        if (ev == EV_ACCEPT) frames_accepted++;
        if (ev == EV_DISCARD) frames_discarded++;
    endtask

    task automatic open_frame(input logic [BYTE_W-1:0] b);
        body_cnt = '0;
        if (b == CH_DOLLAR) begin
            in_nmea = 1'b1;
            xsum    = '0;
            ph      = PH_NBODY;
        end else begin
            in_nmea = 1'b0;
            fl_a    = '0;
            fl_b    = '0;
            ph      = PH_USYNC2;
        end
    endtask

    // fletcher sum update plus body count for one UBX body byte
    task automatic ubx_accumulate(input logic [BYTE_W-1:0] b);
        fl_a     = fl_a + b;
        fl_b     = fl_b + fl_a;
        body_cnt = body_cnt + 1'b1;
    endtask

    function automatic int nibble_of(input logic [BYTE_W-1:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
        if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h37);
        return -1;
    endfunction

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
    endfunction

    // advance the tracked state by one accepted byte, queue any result word
    task automatic predict_byte(input logic [BYTE_W-1:0] b);
        logic                 is_start;
        int                   digit;
        logic [UBX_MAX_W-1:0] claimed_len;
        is_start = (b == CH_DOLLAR) || (b == UBX_SYNC1);
        if (is_start && (ph == PH_WAIT || in_nmea)) begin
            // a start byte while waiting, or any start byte inside NMEA
            if (ph != PH_WAIT) push_word(EV_DISCARD, '0, RS_RESTARTED);
            open_frame(b);
        end else begin
            case (ph)
                PH_NBODY: begin
                    if (b > NMEA_MAX_CODE) begin
                        ph = PH_WAIT;
                        push_word(EV_DISCARD, '0, RS_BAD_CHAR);
                    end else if (b == CH_STAR) begin
                        ph = PH_NCS1;
                    end else if (body_cnt >= max_chars) begin
                        ph = PH_WAIT;
                        push_word(EV_DISCARD, '0, RS_TOO_LONG);
                    end else begin
                        xsum     = xsum ^ b;
                        body_cnt = body_cnt + 1'b1;
                        push_word(EV_BODY, b, RS_NONE);
                    end
                end
                PH_NCS1, PH_NCS2: begin
                    digit = nibble_of(b);
                    if (digit < 0) begin
                        ph = PH_WAIT;
                        push_word(EV_DISCARD, '0, RS_BAD_CHAR);
                    end else if (ph == PH_NCS1) begin
                        xsum = xsum ^ ({digit[3:0], 4'h0} & HIGH_NIBBLE);
                        ph   = PH_NCS2;
                    end else begin
                        xsum = xsum ^ {4'h0, digit[3:0]};
                        ph   = PH_NCR;
                    end
                end
                PH_NCR: begin
                    if (b != CH_CR) begin
                        ph = PH_WAIT;
                        push_word(EV_DISCARD, '0, RS_BAD_TERM);
                    end else begin
                        ph = PH_NLF;
                    end
                end
                PH_NLF: begin
                    ph = PH_WAIT;
                    if (b != CH_LF) push_word(EV_DISCARD, '0, RS_BAD_TERM);
                    else if (xsum != '0) push_word(EV_DISCARD, '0, RS_CHECKSUM);
                    else push_word(EV_ACCEPT, '0, RS_NONE);
                end
                PH_USYNC2: begin
                    if (b == UBX_SYNC2) begin
                        ph = PH_UHDR;
                    end else begin
                        push_word(EV_DISCARD, '0, RS_RESTARTED);
                        if (is_start) open_frame(b);
                        else ph = PH_WAIT;
                    end
                end
                PH_UHDR: begin
                    if (body_cnt == 17'd3) begin
                        // high length byte: check against the limit before passing it on
                        claimed_len = {b, len_lo};
                        if (claimed_len > max_payload) begin
                            ph = PH_WAIT;
                            push_word(EV_DISCARD, '0, RS_TOO_LONG);
                        end else begin
                            pay_len = claimed_len;
                            ubx_accumulate(b);
                            ph = (claimed_len == '0) ? PH_UCK1 : PH_UPAY;
                            push_word(EV_BODY, b, RS_NONE);
                        end
                    end else begin
                        if (body_cnt == 17'd2) len_lo = b;
                        ubx_accumulate(b);
                        push_word(EV_BODY, b, RS_NONE);
                    end
                end
                PH_UPAY: begin
                    ubx_accumulate(b);
                    if (body_cnt >= {1'b0, pay_len} + 17'd4) ph = PH_UCK1;
                    push_word(EV_BODY, b, RS_NONE);
                end
                PH_UCK1: begin
                    if (b != fl_a) begin
                        ph = PH_WAIT;
                        push_word(EV_DISCARD, '0, RS_CHECKSUM);
                    end else begin
                        ph = PH_UCK2;
                    end
                end
                PH_UCK2: begin
                    ph = PH_WAIT;
                    if (b != fl_b) push_word(EV_DISCARD, '0, RS_CHECKSUM);
                    else push_word(EV_ACCEPT, '0, RS_NONE);
                end
                default: ph = PH_WAIT;
            endcase
        end
    endtask

    // ---------------------------------------------------------------
    // drivers
    // ---------------------------------------------------------------

    task automatic set_idling(input int tx_pct, input int rx_pct);
        tx_gap_pct   = tx_pct;
        rx_stall_pct = rx_pct;
    endtask

    // offer one byte, maybe after a short gap, and track it once taken
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        @(negedge clk);
        if ($urandom_range(99) < tx_gap_pct) begin
            rx_bus.valid = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        rx_bus.valid   = 1'b1;
        rx_bus.rx_byte = b;
        do @(posedge clk); while (!rx_bus.ready);
        predict_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame_buf;
        foreach (frame_buf[i]) send_byte(frame_buf[i]);
    endtask

    // drop valid, wait for every expected word, then let the pipeline empty
    task automatic settle_block;
        @(negedge clk);
        rx_bus.valid = 1'b0;
        while (expected_words.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = value;
        @(posedge clk);
        if (idx == CFG_NMEA_MAX_CHARS) max_chars = value[NMEA_MAX_W-1:0];
        else max_payload = value[UBX_MAX_W-1:0];
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // frame builders
    // ---------------------------------------------------------------

    task automatic build_nmea(input int body_len, input bit good_sum);
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] sum;
        frame_buf.delete();
        frame_buf.push_back(CH_DOLLAR);
        sum = '0;
        for (int i = 0; i < body_len; i++) begin
            do c = $urandom_range(127); while (c == CH_DOLLAR || c == CH_STAR);
            sum = sum ^ c;
            frame_buf.push_back(c);
        end
        if (!good_sum) sum = sum ^ (8'h01 << $urandom_range(7));
        frame_buf.push_back(CH_STAR);
        frame_buf.push_back(hex_char(sum[7:4]));
        frame_buf.push_back(hex_char(sum[3:0]));
        frame_buf.push_back(CH_CR);
        frame_buf.push_back(CH_LF);
    endtask

    // seed_starts puts both start bytes at the head of the payload
    task automatic build_ubx(input int plen, input bit bad_a, input bit bad_b,
                             input bit seed_starts);
        logic [BYTE_W-1:0] c;
        logic [BYTE_W-1:0] ck_a;
        logic [BYTE_W-1:0] ck_b;
        frame_buf.delete();
        frame_buf.push_back(UBX_SYNC1);
        frame_buf.push_back(UBX_SYNC2);
        frame_buf.push_back($urandom_range(255));
        frame_buf.push_back($urandom_range(255));
        frame_buf.push_back(plen[7:0]);
        frame_buf.push_back(plen[15:8]);
        for (int i = 0; i < plen; i++) begin
            c = $urandom_range(255);
            if (seed_starts && i == 0) c = CH_DOLLAR;
            if (seed_starts && i == 1) c = UBX_SYNC1;
            frame_buf.push_back(c);
        end
        ck_a = '0;
        ck_b = '0;
        for (int i = 2; i < frame_buf.size(); i++) begin
            ck_a = ck_a + frame_buf[i];
            ck_b = ck_b + ck_a;
        end
        frame_buf.push_back(bad_a ? ck_a ^ 8'h80 : ck_a);
        frame_buf.push_back(bad_b ? ck_b ^ 8'h01 : ck_b);
    endtask

    // truncate or overwrite one byte; UBX length bytes stay intact so a
    // broken frame never claims a huge payload
    task automatic break_frame(input bit is_ubx);
        int pos;
        if ($urandom_range(1) == 0) begin
            pos = $urandom_range(frame_buf.size() - 1, 1);
            while (frame_buf.size() > pos) void'(frame_buf.pop_back());
        end else begin
            pos = $urandom_range(frame_buf.size() - 1);
            if (is_ubx && (pos == UBX_LEN_LO_POS || pos == UBX_LEN_HI_POS)) pos = 1;
            frame_buf[pos] = $urandom_range(255);
        end
    endtask

    // ---------------------------------------------------------------
    // result checking
    // ---------------------------------------------------------------

    task automatic report_field(input string name, input logic [31:0] want_v,
                                input logic [31:0] got_v);
        if (want_v !== got_v)
            $display("%0t ns: %s expected %0d actual %0d", $time, name, want_v, got_v);
    endtask

    always @(posedge clk) begin
        if (rst_n && res_bus.valid && res_bus.ready) begin
            got_word.event_res      = res_bus.event_res;
            got_word.protocol       = res_bus.protocol;
            got_word.body_byte      = res_bus.body_byte;
            got_word.frame_length   = res_bus.frame_length;
            got_word.discard_reason = res_bus.discard_reason;
            if (expected_words.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: word with nothing expected, event %0d length %0d",
                         $time, got_word.event_res, got_word.frame_length);
            end else begin
                want_word = expected_words.pop_front();
                words_checked++;
                if (got_word !== want_word) begin
                    mismatch_count++;
                    report_field("event", want_word.event_res, got_word.event_res);
                    report_field("protocol", want_word.protocol, got_word.protocol);
                    report_field("body byte", want_word.body_byte, got_word.body_byte);
                    report_field("length", want_word.frame_length, got_word.frame_length);
                    report_field("reason", want_word.discard_reason,
                                 got_word.discard_reason);
                end
            end
        end
    end

    // receiver: random stalls, or a counted hold-off when one is requested
    initial begin
        res_bus.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                res_bus.ready = 1'b0;
                hold_left--;
            end else begin
                res_bus.ready = ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    task automatic test_idle_bytes;
        frame_buf = {8'h00, 8'hFF, UBX_SYNC2, CH_STAR, CH_CR, CH_LF};
        send_frame_buf();
    endtask

    task automatic test_nmea_framing;
        // empty body, good sentence, checksum mismatch
        frame_buf = {CH_DOLLAR, CH_STAR, "0", "0", CH_CR, CH_LF};
        send_frame_buf();
        frame_buf = {CH_DOLLAR, "G", "P", CH_STAR, "1", "7", CH_CR, CH_LF};
        send_frame_buf();
        frame_buf = {CH_DOLLAR, "G", "P", CH_STAR, "1", "8", CH_CR, CH_LF};
        send_frame_buf();
        // bad checksum digits, lowercase and non-hex
        frame_buf = {CH_DOLLAR, "G", "P", CH_STAR, "1", "a"};
        send_frame_buf();
        frame_buf = {CH_DOLLAR, "G", CH_STAR, "Z"};
        send_frame_buf();
        // bad terminators
        frame_buf = {CH_DOLLAR, "G", CH_STAR, "4", "7", "X"};
        send_frame_buf();
        frame_buf = {CH_DOLLAR, "G", CH_STAR, "4", "7", CH_CR, CH_CR};
        send_frame_buf();
        // body character above 7 bits
        frame_buf = {CH_DOLLAR, "G", 8'hFF};
        send_frame_buf();
        // restarts in body, in the digits, before CR and before LF
        frame_buf = {CH_DOLLAR, "G", "P", CH_DOLLAR, "G", CH_STAR, "4", "7", CH_CR, CH_LF};
        send_frame_buf();
        frame_buf = {CH_DOLLAR, "G", CH_STAR, CH_DOLLAR, CH_STAR, "0", CH_DOLLAR,
                     CH_STAR, "0", "0", CH_DOLLAR, CH_STAR, "0", "0", CH_CR,
                     CH_DOLLAR, CH_STAR, "0", "0", CH_CR, CH_LF};
        send_frame_buf();
        // 0xB5 cuts the sentence short and opens a UBX frame
        frame_buf = {CH_DOLLAR, "G", "P"};
        send_frame_buf();
        build_ubx(1, 1'b0, 1'b0, 1'b0);
        send_frame_buf();
    endtask

    task automatic test_ubx_framing;
        build_ubx(0, 1'b0, 1'b0, 1'b0);
        send_frame_buf();
        // wrong second sync: plain byte, then '$', then a second 0xB5
        frame_buf = {UBX_SYNC1, 8'h00};
        send_frame_buf();
        frame_buf = {UBX_SYNC1, CH_DOLLAR, CH_STAR, "0", "0", CH_CR, CH_LF};
        send_frame_buf();
        frame_buf = {UBX_SYNC1};
        send_frame_buf();
        build_ubx(2, 1'b0, 1'b0, 1'b0);
        send_frame_buf();
        // start bytes as payload data
        build_ubx(4, 1'b0, 1'b0, 1'b1);
        send_frame_buf();
        // checksum wrong in the first and in the second byte
        build_ubx(3, 1'b1, 1'b0, 1'b0);
        send_frame_buf();
        build_ubx(3, 1'b0, 1'b1, 1'b0);
        send_frame_buf();
        // one over the reset payload limit
        frame_buf = {UBX_SYNC1, UBX_SYNC2, 8'h01, 8'h02, 8'hFD, 8'h00};
        send_frame_buf();
    endtask

    task automatic test_register_limits;
        settle_block();
        // upper data bits are dropped, leaving a one-character limit
        write_reg(CFG_NMEA_MAX_CHARS, 16'hF801);
        write_reg(CFG_UBX_MAX_PAYLOAD, 16'd0);
        frame_buf = {CH_DOLLAR, "G", CH_STAR, "4", "7", CH_CR, CH_LF};
        send_frame_buf();
        frame_buf = {CH_DOLLAR, "G", "P", CH_STAR, "1", "7", CH_CR, CH_LF};
        send_frame_buf();
        build_ubx(0, 1'b0, 1'b0, 1'b0);
        send_frame_buf();
        frame_buf = {UBX_SYNC1, UBX_SYNC2, 8'h0A, 8'h0B, 8'h00, 8'h80};
        send_frame_buf();
        frame_buf = {UBX_SYNC1, UBX_SYNC2, 8'hFF, 8'hFF, 8'h01, 8'h00};
        send_frame_buf();
        settle_block();
        write_reg(CFG_NMEA_MAX_CHARS, 16'd1024);
        write_reg(CFG_UBX_MAX_PAYLOAD, 16'hFFFF);
        build_nmea(30, 1'b1);
        send_frame_buf();
        build_ubx(40, 1'b0, 1'b0, 1'b0);
        send_frame_buf();
    endtask

    // mostly well-formed frames with random content, some broken, some noise
    task automatic test_random_traffic(input int byte_budget);
        int stop_at;
        int pick;
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                build_nmea($urandom_range(20), $urandom_range(9) != 0);
                if ($urandom_range(4) == 0) break_frame(1'b0);
            end else if (pick < 88) begin
                build_ubx($urandom_range(24), $urandom_range(11) == 0,
                          $urandom_range(11) == 0, $urandom_range(7) == 0);
                if ($urandom_range(4) == 0) break_frame(1'b1);
            end else begin
                frame_buf.delete();
                repeat ($urandom_range(4, 1)) frame_buf.push_back($urandom_range(255));
            end
            send_frame_buf();
        end
    endtask

    // receiver holds off while body-heavy frames keep coming, so the block
    // backs up and stalls its input
    task automatic test_output_stall;
        settle_block();
        hold_left = 160;
        build_ubx(18, 1'b0, 1'b0, 1'b0);
        send_frame_buf();
        build_nmea(14, 1'b1);
        send_frame_buf();
        build_ubx(18, 1'b0, 1'b0, 1'b0);
        send_frame_buf();
    endtask

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        rst_n          = 1'b0;
        rx_bus.valid   = 1'b0;
        rx_bus.rx_byte = '0;
        cfg_we         = 1'b0;
        cfg_idx        = CFG_NMEA_MAX_CHARS;
        cfg_data       = '0;
        hold_left      = 0;
        bytes_sent       = 0;
        words_checked    = 0;
        mismatch_count   = 0;
        frames_accepted  = 0;
        frames_discarded = 0;
        set_idling(0, 0);
        ph          = PH_WAIT;
        in_nmea     = 1'b1;
        xsum        = '0;
        fl_a        = '0;
        fl_b        = '0;
        len_lo      = '0;
        pay_len     = '0;
        body_cnt    = '0;
        max_chars   = NMEA_MAX_RESET;
        max_payload = UBX_MAX_RESET;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;

        // sender sparse gaps, receiver stalls often
        set_idling(12, 73);
        test_idle_bytes();
        test_nmea_framing();
        test_ubx_framing();
        test_register_limits();
        test_random_traffic(90);

        // sender gaps often, receiver stalls rarely
        settle_block();
        write_reg(CFG_NMEA_MAX_CHARS, 16'd8);
        write_reg(CFG_UBX_MAX_PAYLOAD, 16'd12);
        set_idling(73, 12);
        test_random_traffic(85);

        // back to back on both sides
        settle_block();
        write_reg(CFG_NMEA_MAX_CHARS, 16'd16);
        write_reg(CFG_UBX_MAX_PAYLOAD, 16'd20);
        set_idling(0, 0);
        test_random_traffic(85);
        test_output_stall();

        settle_block();
        $display("ran %0d bytes through the deframer, checked %0d result words",
                 bytes_sent, words_checked);
        $display("%0d frames accepted, %0d discarded, under five register settings",
                 frames_accepted, frames_discarded);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // watchdog against a hung handshake
    initial begin
        #(WATCHDOG_CYCLES * CLK_PERIOD);
        $display("timeout with %0d words still expected", expected_words.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
